@@ hdl/mts_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mts_pkg;

    localparam int DEF_STACK_DEPTH = 64;
    localparam int DEF_WORD_BITS   = 32;

    localparam int OPCODE_BITS = 2;
    localparam int STATUS_BITS = 2;

    localparam logic [OPCODE_BITS-1:0] OP_PUSH = 2'd0;
    localparam logic [OPCODE_BITS-1:0] OP_POP  = 2'd1;
    localparam logic [OPCODE_BITS-1:0] OP_PEEK = 2'd2;

    localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_UNDERFLOW = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_FETCH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;    // transaction taken on the input channel this cycle
        logic pop_load;  // refill the cached tops from the registered reads
    } mts_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pop_fetch; // offered item is a pop on a non-empty stack
    } mts_stat_t;

endpackage

`default_nettype wire

@@ hdl/mts_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface mts_in_if #(
    parameter int WORD_BITS = mts_pkg::DEF_WORD_BITS
);
    logic                             valid;
    logic                             ready;
    logic [mts_pkg::OPCODE_BITS-1:0]  opcode;
    logic signed [WORD_BITS-1:0]      push_value;

    modport source (output valid, output opcode, output push_value, input ready);
    modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface mts_out_if #(
    parameter int WORD_BITS = mts_pkg::DEF_WORD_BITS
);
    logic                             valid;
    logic                             ready;
    logic signed [WORD_BITS-1:0]      top_value;
    logic signed [WORD_BITS-1:0]      min_value;
    logic                             is_empty;
    logic [mts_pkg::STATUS_BITS-1:0]  status;

    modport source (output valid, output top_value, output min_value,
                    output is_empty, output status, input ready);
    modport sink   (input valid, input top_value, input min_value,
                    input is_empty, input status, output ready);
endinterface

`default_nettype wire

@@ hdl/mts_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mts_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    input  wire mts_pkg::mts_stat_t stat,
    output mts_pkg::mts_cmd_t       cmd
);
    import mts_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        in_ready       = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
        accept         = in_ready && in_valid;
        cmd.accept     = accept;
        cmd.pop_load   = 1'b0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (stat.pop_fetch)
                        state_next = S_FETCH;
                    else
                        out_valid_next = 1'b1;
                end
            end
            S_FETCH:
            begin
                // read data for the new tops has landed; finish the pop
                cmd.pop_load   = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ hdl/mts_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mts_dp #(
    parameter int STACK_DEPTH = mts_pkg::DEF_STACK_DEPTH,
    parameter int WORD_BITS   = mts_pkg::DEF_WORD_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire mts_pkg::mts_cmd_t               cmd,
    output mts_pkg::mts_stat_t                   stat,
    input  wire logic [mts_pkg::OPCODE_BITS-1:0] opcode,
    input  wire logic signed [WORD_BITS-1:0]     push_value,
    output logic signed [WORD_BITS-1:0]          top_value,
    output logic signed [WORD_BITS-1:0]          min_value,
    output logic                                 is_empty,
    output logic [mts_pkg::STATUS_BITS-1:0]      status
);
    import mts_pkg::*;

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // the top of each stack lives in a register; memories hold what lies below
    logic signed [WORD_BITS-1:0] main_mem [STACK_DEPTH];
    logic signed [WORD_BITS-1:0] min_mem  [STACK_DEPTH];

    logic [CNT_W-1:0]            count_reg, count_next, mcount_reg, mcount_next;
    logic                        pop_min_reg, pop_min_next;
    logic signed [WORD_BITS-1:0] top_reg, top_next, min_reg, min_next;
    logic signed [WORD_BITS-1:0] rd_main_reg, rd_min_reg;

    logic signed [WORD_BITS-1:0] top_value_reg, min_value_reg;
    logic                        is_empty_reg;
    logic [STATUS_BITS-1:0]      status_reg;

    logic signed [WORD_BITS-1:0] res_top, res_min;
    logic                        res_empty, res_load;
    logic [STATUS_BITS-1:0]      res_status;

    logic                        full, empty, min_take;
    logic                        main_wr, min_wr;
    logic [CNT_W-1:0]            count_m1, count_m2, mcount_m1, mcount_m2;

    assign full      = (count_reg == CNT_W'(STACK_DEPTH));
    assign empty     = (count_reg == '0);
    assign min_take  = (mcount_reg == '0) || (push_value <= min_reg);
    assign count_m1  = count_reg - CNT_W'(1);
    assign count_m2  = count_reg - CNT_W'(2);
    assign mcount_m1 = mcount_reg - CNT_W'(1);
    assign mcount_m2 = mcount_reg - CNT_W'(2);

    assign stat.pop_fetch = (opcode == OP_POP) && !empty;

    // spill the cached tops into memory when a push covers them
    assign main_wr = cmd.accept && (opcode == OP_PUSH) && !full && !empty;
    assign min_wr  = cmd.accept && (opcode == OP_PUSH) && !full && min_take &&
                     (mcount_reg != '0);

    always_ff @(posedge clk)
    begin
        if (main_wr)
            main_mem[count_m1[ADDR_W-1:0]] <= top_reg;
        if (min_wr)
            min_mem[mcount_m1[ADDR_W-1:0]] <= min_reg;
        rd_main_reg <= main_mem[count_m2[ADDR_W-1:0]];
        rd_min_reg  <= min_mem[mcount_m2[ADDR_W-1:0]];
    end

    always_comb
    begin
        count_next   = count_reg;
        mcount_next  = mcount_reg;
        pop_min_next = pop_min_reg;
        top_next     = top_reg;
        min_next     = min_reg;
        res_load     = 1'b0;
        res_status   = ST_OK;
        res_empty    = empty;
        res_top      = empty ? '0 : top_reg;
        res_min      = empty ? '0 : min_reg;
        if (cmd.accept)
        begin
            case (opcode)
                OP_PUSH:
                begin
                    res_load = 1'b1;
                    if (full)
                    begin
                        res_status = ST_OVERFLOW;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                        top_next   = push_value;
                        res_top    = push_value;
                        res_empty  = 1'b0;
                        if (min_take)
                        begin
                            mcount_next = mcount_reg + CNT_W'(1);
                            min_next    = push_value;
                            res_min     = push_value;
                        end
                        else
                        begin
                            res_min = min_reg;
                        end
                    end
                end
                OP_POP:
                begin
                    if (empty)
                    begin
                        res_load   = 1'b1;
                        res_status = ST_UNDERFLOW;
                    end
                    else
                    begin
                        // drop the counts now; tops refill after the read
                        count_next   = count_m1;
                        pop_min_next = (min_reg == top_reg);
                        if (min_reg == top_reg)
                            mcount_next = mcount_m1;
                    end
                end
                default:
                begin
                    res_load = 1'b1;
                end
            endcase
        end
        if (cmd.pop_load)
        begin
            res_load  = 1'b1;
            top_next  = rd_main_reg;
            if (pop_min_reg)
                min_next = rd_min_reg;
            res_top   = empty ? '0 : rd_main_reg;
            res_min   = empty ? '0 : (pop_min_reg ? rd_min_reg : min_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            mcount_reg  <= '0;
            pop_min_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            mcount_reg  <= mcount_next;
            pop_min_reg <= pop_min_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        min_reg <= min_next;
        if (res_load)
        begin
            top_value_reg <= res_top;
            min_value_reg <= res_min;
            is_empty_reg  <= res_empty;
            status_reg    <= res_status;
        end
    end

    assign top_value = top_value_reg;
    assign min_value = min_value_reg;
    assign is_empty  = is_empty_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

@@ hdl/min_tracking_stack_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Timing: push, peek, overflow and underflow results are valid in the cycle after the transaction;
//   a pop on a non-empty stack passes the fetch state first (registered memory read of the new tops).
// Throughput: 1 item per cycle for push, peek and the error cases while out_ready holds; a pop
//   on a non-empty stack holds the input off during its fetch cycle.
// Reset (rst_n low, asynchronous): both counts and the output valid flag clear; the result register
//   and the stack memories are not cleared, and the memories are only read below the counts.
module min_tracking_stack_unit #(
    parameter int STACK_DEPTH = mts_pkg::DEF_STACK_DEPTH,
    parameter int WORD_BITS   = mts_pkg::DEF_WORD_BITS
) (
    input wire logic clk,
    input wire logic rst_n,
    mts_in_if.sink   in_ch,
    mts_out_if.source out_ch
);
    import mts_pkg::*;

    mts_cmd_t  cmd;
    mts_stat_t stat;

    // Controller: sequences the input handshake, the extra fetch cycle of a pop
    // and the valid flag of the result register.
    mts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: counts, cached tops of both stacks, the two stack memories and
    // the result register. A push spills the old tops into memory; a pop reads
    // the entries just below and refills the caches in the cycle after.
    mts_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .WORD_BITS   (WORD_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .opcode     (in_ch.opcode),
        .push_value (in_ch.push_value),
        .top_value  (out_ch.top_value),
        .min_value  (out_ch.min_value),
        .is_empty   (out_ch.is_empty),
        .status     (out_ch.status)
    );

`ifndef NO_ASSERTIONS
    // an empty stack reads zero on both words
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.is_empty |-> out_ch.top_value == '0 && out_ch.min_value == '0)
        else $error("empty result with nonzero top or minimum");

    // underflow only ever happens on an empty stack
    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.status == ST_UNDERFLOW |-> out_ch.is_empty)
        else $error("underflow reported on a non-empty stack");

    // a pop that needs a refill blocks the input for its fetch cycle
    a_pop_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready && stat.pop_fetch |=> !in_ch.ready && cmd.pop_load)
        else $error("input not held during pop refill");

    // refill only directly after an accepted pop
    a_load_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_load |-> $past(in_ch.valid && in_ch.ready && stat.pop_fetch))
        else $error("refill without a preceding pop");
`endif

endmodule

`default_nettype wire
